// ----- sv/krhs_pkg.sv -----
`default_nettype none
package krhs_pkg;

   localparam int CMD_W   = 2;
   localparam int ID_W    = 32;
   localparam int SID_W   = 32;
   localparam int PL_W    = 64;
   localparam int WANT_W  = 7;
   localparam int FILL_W  = 7;
   localparam int TOTAL_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_COPY   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic             src_valid;
      logic [SID_W-1:0] src_id;
      logic [PL_W-1:0]  payload;
   } record_type;

   localparam int REC_W = $bits(record_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_COPY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic reject;
      logic scan_init;
      logic scan;
      logic finish_hit;
      logic finish_miss;
      logic copy_init;
      logic copy;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    id_pos;
      logic    hit;
      logic    miss;
      logic    copy_empty;
      logic    copy_done;
   } sts_type;

endpackage
`default_nettype wire

// ----- sv/keyed_ring_history_store.sv -----
// clear and reject: the request is registered, then dispatch registers the result strobe;
// append and lookup walk the ring newest to oldest, one record memory read per cycle
// copy of n records: set-up, memory read and result registers, then one result per cycle
// one request at a time; busy is high until the last result is registered
// results cannot be stalled; reset (synchronous) empties the ring and zeroes the total
`default_nettype none
module keyed_ring_history_store import krhs_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [CMD_W-1:0]        req_command,
   input  wire logic signed [ID_W-1:0]  req_record_id,
   input  wire logic                    req_source_valid,
   input  wire logic signed [SID_W-1:0] req_source_id,
   input  wire logic [PL_W-1:0]         req_payload,
   input  wire logic [WANT_W-1:0]       req_max_wanted,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic signed [ID_W-1:0]       rsp_out_id,
   output logic                         rsp_out_source_valid,
   output logic signed [SID_W-1:0]      rsp_out_source_id,
   output logic [PL_W-1:0]              rsp_out_payload,
   output logic [FILL_W-1:0]            rsp_fill,
   output logic [TOTAL_W-1:0]           rsp_total_added,
   output logic                         rsp_last
);

   ctl_type ctl;
   sts_type sts;

   krhs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   krhs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .sts                  (sts),
      .req_command          (req_command),
      .req_record_id        (req_record_id),
      .req_source_valid     (req_source_valid),
      .req_source_id        (req_source_id),
      .req_payload          (req_payload),
      .req_max_wanted       (req_max_wanted),
      .rsp_valid            (rsp_valid),
      .rsp_ok               (rsp_ok),
      .rsp_out_id           (rsp_out_id),
      .rsp_out_source_valid (rsp_out_source_valid),
      .rsp_out_source_id    (rsp_out_source_id),
      .rsp_out_payload      (rsp_out_payload),
      .rsp_fill             (rsp_fill),
      .rsp_total_added      (rsp_total_added),
      .rsp_last             (rsp_last)
   );

endmodule
`default_nettype wire

// ----- sv/krhs_ram.sv -----
`default_nettype none
module krhs_ram #(
   parameter int WIDTH = 129,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- sv/krhs_ctrl.sv -----
`default_nettype none
module krhs_ctrl import krhs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire sts_type sts,
   output ctl_type      ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.cmd)
               CMD_CLEAR: begin
                  ctl.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
               CMD_APPEND, CMD_LOOKUP: begin
                  if (sts.id_pos) begin
                     ctl.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end else begin
                     ctl.reject = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
               CMD_COPY: begin
                  if (sts.copy_empty) begin
                     ctl.reject = 1'b1;
                     state_in   = ST_IDLE;
                  end else begin
                     ctl.copy_init = 1'b1;
                     state_in      = ST_COPY;
                  end
               end
               default: begin
                  ctl.reject = 1'b1;
                  state_in   = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            ctl.scan = 1'b1;
            priority if (sts.hit) begin
               ctl.finish_hit = 1'b1;
               state_in       = ST_IDLE;
            end else if (sts.miss) begin
               ctl.finish_miss = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_COPY: begin
            ctl.copy = 1'b1;
            if (sts.copy_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/krhs_datapath.sv -----
`default_nettype none
module krhs_datapath import krhs_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctl_type                 ctl,
   output sts_type                      sts,
   input  wire logic [CMD_W-1:0]        req_command,
   input  wire logic signed [ID_W-1:0]  req_record_id,
   input  wire logic                    req_source_valid,
   input  wire logic signed [SID_W-1:0] req_source_id,
   input  wire logic [PL_W-1:0]         req_payload,
   input  wire logic [WANT_W-1:0]       req_max_wanted,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic signed [ID_W-1:0]       rsp_out_id,
   output logic                         rsp_out_source_valid,
   output logic signed [SID_W-1:0]      rsp_out_source_id,
   output logic [PL_W-1:0]              rsp_out_payload,
   output logic [FILL_W-1:0]            rsp_fill,
   output logic [TOTAL_W-1:0]           rsp_total_added,
   output logic                         rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                              input logic [AW-1:0] p);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, p};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   cmd_type           cmd_ff, cmd_in;
   record_type        rec_ff, rec_in;
   logic [WANT_W-1:0] want_ff, want_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic              rv_ff, rv_in;
   logic [AW-1:0]     rslot_ff, rslot_in;
   logic              rlast_ff, rlast_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   record_type        rsp_rec_ff, rsp_rec_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [REC_W-1:0]  rd_data;
   record_type        rd_rec;
   logic              issue;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              id_match, src_match, match, hit, miss, full;
   logic [CW-1:0]     copy_n;

   krhs_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rec_ff),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_rec    = record_type'(rd_data);
   assign id_match  = rd_rec.id == rec_ff.id;
   assign src_match = rec_ff.src_valid && rd_rec.src_valid && (rec_ff.src_id != '0) &&
                      (rd_rec.src_id == rec_ff.src_id);
   assign match     = (cmd_ff == CMD_APPEND) ? (id_match || src_match) : id_match;
   assign hit       = rv_ff && match;
   // the last read in flight has been checked without a match
   assign miss      = (rem_ff == '0) && !hit;
   assign full      = count_ff == CW'(DEPTH);
   assign copy_n    = (want_ff < WANT_W'(count_ff)) ? CW'(want_ff) : count_ff;

   assign sts.cmd        = cmd_ff;
   assign sts.id_pos     = (rec_ff.id != '0) && !rec_ff.id[ID_W-1];
   assign sts.hit        = hit;
   assign sts.miss       = miss;
   assign sts.copy_empty = copy_n == '0;
   assign sts.copy_done  = rv_ff && rlast_ff;

   always_comb begin
      issue   = 1'b0;
      rd_addr = ring_pos(oldest_ff, pos_ff);
      if (ctl.scan) begin
         // newest to oldest
         issue   = (rem_ff != '0) && !hit;
         rd_addr = ring_pos(oldest_ff, AW'(rem_ff - CW'(1)));
      end else if (ctl.copy) begin
         issue = rem_ff != '0;
      end
   end

   assign wr_en   = (ctl.finish_hit || ctl.finish_miss) && (cmd_ff == CMD_APPEND);
   assign wr_addr = ctl.finish_hit ? rslot_ff :
                    (full ? oldest_ff : ring_pos(oldest_ff, AW'(count_ff)));

   always_comb begin
      cmd_in       = cmd_ff;
      rec_in       = rec_ff;
      want_in      = want_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      rv_in        = 1'b0;
      rslot_in     = rslot_ff;
      rlast_in     = rlast_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;

      if (ctl.load) begin
         cmd_in            = cmd_type'(req_command);
         rec_in.id         = $unsigned(req_record_id);
         rec_in.src_valid  = req_source_valid;
         rec_in.src_id     = $unsigned(req_source_id);
         rec_in.payload    = req_payload;
         want_in           = req_max_wanted;
      end

      if (ctl.clear) begin
         count_in     = '0;
         oldest_in    = '0;
         total_in     = '0;
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b1;
         rsp_rec_in   = '0;
         rsp_last_in  = 1'b1;
      end

      if (ctl.reject) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b0;
         rsp_rec_in   = '0;
         rsp_last_in  = 1'b1;
      end

      if (ctl.scan_init) begin
         rem_in = count_ff;
      end

      if (ctl.scan && issue) begin
         rem_in   = rem_ff - CW'(1);
         rv_in    = 1'b1;
         rslot_in = rd_addr;
      end

      if (ctl.finish_hit) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b1;
         rsp_rec_in   = (cmd_ff == CMD_LOOKUP) ? rd_rec : '0;
         rsp_last_in  = 1'b1;
      end

      if (ctl.finish_miss) begin
         rsp_valid_in = 1'b1;
         rsp_rec_in   = '0;
         rsp_last_in  = 1'b1;
         if (cmd_ff == CMD_APPEND) begin
            rsp_ok_in = 1'b1;
            total_in  = total_ff + TOTAL_W'(1);
            if (full) begin
               oldest_in = (oldest_ff == AW'(DEPTH - 1)) ? '0 : oldest_ff + AW'(1);
            end else begin
               count_in = count_ff + CW'(1);
            end
         end else begin
            rsp_ok_in = 1'b0;
         end
      end

      if (ctl.copy_init) begin
         rem_in = copy_n;
         pos_in = AW'(count_ff - copy_n);
      end

      if (ctl.copy) begin
         if (issue) begin
            rem_in   = rem_ff - CW'(1);
            pos_in   = pos_ff + AW'(1);
            rv_in    = 1'b1;
            rlast_in = rem_ff == CW'(1);
         end
         if (rv_ff) begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_rec_in   = rd_rec;
            rsp_last_in  = rlast_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         oldest_ff    <= '0;
         total_ff     <= '0;
         rem_ff       <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         total_ff     <= total_in;
         rem_ff       <= rem_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rec_ff      <= rec_in;
      want_ff     <= want_in;
      pos_ff      <= pos_in;
      rslot_ff    <= rslot_in;
      rlast_ff    <= rlast_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ok               = rsp_ok_ff;
   assign rsp_out_id           = $signed(rsp_rec_ff.id);
   assign rsp_out_source_valid = rsp_rec_ff.src_valid;
   assign rsp_out_source_id    = $signed(rsp_rec_ff.src_id);
   assign rsp_out_payload      = rsp_rec_ff.payload;
   assign rsp_fill             = FILL_W'(count_ff);
   assign rsp_total_added      = total_ff;
   assign rsp_last             = rsp_last_ff;

endmodule
`default_nettype wire

// ----- bench/tb_keyed_ring_history_store.sv -----
`default_nettype none
module tb_keyed_ring_history_store;
   import krhs_pkg::*;

   localparam int RING_DEPTH   = 64;
   localparam int HALF_PERIOD  = 4;
   localparam int RANDOM_ITEMS = 470;
   localparam int RUN_LIMIT    = 4000000;

   typedef struct {
      logic               ok;
      logic [ID_W-1:0]    id;
      logic               src_valid;
      logic [SID_W-1:0]   src_id;
      logic [PL_W-1:0]    payload;
      logic [FILL_W-1:0]  fill;
      logic [TOTAL_W-1:0] total;
      logic               last;
   } reply_type;

   class ring_history_scoreboard;
      logic [ID_W-1:0]    slot_id  [RING_DEPTH];
      logic               slot_sv  [RING_DEPTH];
      logic [SID_W-1:0]   slot_sid [RING_DEPTH];
      logic [PL_W-1:0]    slot_pl  [RING_DEPTH];
      int                 held = 0;
      int                 oldest = 0;
      logic [TOTAL_W-1:0] added = '0;
      reply_type          awaited_replies[$];
      int                 fail_count = 0;
      int                 reply_count = 0;

      function void push_reply(logic ok, int slot, logic has_rec, logic last);
         reply_type r;
         r.ok        = ok;
         r.id        = has_rec ? slot_id[slot]  : '0;
         r.src_valid = has_rec ? slot_sv[slot]  : 1'b0;
         r.src_id    = has_rec ? slot_sid[slot] : '0;
         r.payload   = has_rec ? slot_pl[slot]  : '0;
         r.fill      = FILL_W'(held);
         r.total     = added;
         r.last      = last;
         awaited_replies.push_back(r);
      endfunction

      function void store_record(int s, logic [ID_W-1:0] id, logic sv,
                                 logic [SID_W-1:0] sid, logic [PL_W-1:0] pl);
         slot_id[s]  = id;
         slot_sv[s]  = sv;
         slot_sid[s] = sid;
         slot_pl[s]  = pl;
      endfunction

      function void note_request(cmd_type cmd, logic [ID_W-1:0] id, logic sv,
                                 logic [SID_W-1:0] sid, logic [PL_W-1:0] pl,
                                 logic [WANT_W-1:0] want);
         int  i;
         int  s;
         int  n;
         logic positive;
         logic same_src;
         positive = (id != '0) && !id[ID_W-1];
         case (cmd)
            CMD_CLEAR: begin
               held   = 0;
               oldest = 0;
               added  = '0;
               push_reply(1'b1, 0, 1'b0, 1'b1);
            end
            CMD_APPEND: begin
               if (!positive) begin
                  push_reply(1'b0, 0, 1'b0, 1'b1);
                  return;
               end
               // newest to oldest, first id or live source match is replaced in place
               for (i = held; i > 0; i--) begin
                  s = (oldest + i - 1) % RING_DEPTH;
                  same_src = sv && slot_sv[s] && (sid != '0) && (slot_sid[s] == sid);
                  if (slot_id[s] == id || same_src) begin
                     store_record(s, id, sv, sid, pl);
                     push_reply(1'b1, 0, 1'b0, 1'b1);
                     return;
                  end
               end
               if (held < RING_DEPTH) begin
                  store_record((oldest + held) % RING_DEPTH, id, sv, sid, pl);
                  held++;
               end else begin
                  store_record(oldest, id, sv, sid, pl);
                  oldest = (oldest + 1) % RING_DEPTH;
               end
               added = added + 1'b1;
               push_reply(1'b1, 0, 1'b0, 1'b1);
            end
            CMD_LOOKUP: begin
               if (positive) begin
                  for (i = held; i > 0; i--) begin
                     s = (oldest + i - 1) % RING_DEPTH;
                     if (slot_id[s] == id) begin
                        push_reply(1'b1, s, 1'b1, 1'b1);
                        return;
                     end
                  end
               end
               push_reply(1'b0, 0, 1'b0, 1'b1);
            end
            default: begin
               n = (int'(want) < held) ? int'(want) : held;
               if (n == 0) begin
                  push_reply(1'b0, 0, 1'b0, 1'b1);
               end else begin
                  for (i = 0; i < n; i++) begin
                     push_reply(1'b1, (oldest + held - n + i) % RING_DEPTH, 1'b1, i == n - 1);
                  end
               end
            end
         endcase
      endfunction

      task report(string msg);
         $display("%0t: %s", $realtime, msg);
         fail_count++;
      endtask

      task check_result(reply_type got);
         reply_type exp_r;
         string     bad;
         reply_count++;
         if (awaited_replies.size() == 0) begin
            report($sformatf("reply %0d arrived with none pending: ok=%b id=%h last=%b",
                             reply_count, got.ok, got.id, got.last));
            return;
         end
         exp_r = awaited_replies.pop_front();
         bad = "";
         if (got.ok !== exp_r.ok)               bad = {bad, " ok"};
         if (got.id !== exp_r.id)               bad = {bad, " id"};
         if (got.src_valid !== exp_r.src_valid) bad = {bad, " source_valid"};
         if (got.src_id !== exp_r.src_id)       bad = {bad, " source_id"};
         if (got.payload !== exp_r.payload)     bad = {bad, " payload"};
         if (got.fill !== exp_r.fill)           bad = {bad, " fill"};
         if (got.total !== exp_r.total)         bad = {bad, " total_added"};
         if (got.last !== exp_r.last)           bad = {bad, " last"};
         if (bad != "") begin
            report($sformatf({"reply %0d bad%s: got %b %h %b %h %h %0d %0d %b,",
                              " want %b %h %b %h %h %0d %0d %b"}, reply_count, bad,
                             got.ok, got.id, got.src_valid, got.src_id, got.payload,
                             got.fill, got.total, got.last,
                             exp_r.ok, exp_r.id, exp_r.src_valid, exp_r.src_id,
                             exp_r.payload, exp_r.fill, exp_r.total, exp_r.last));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start;
   logic                     busy;
   logic [CMD_W-1:0]         req_command;
   logic signed [ID_W-1:0]   req_record_id;
   logic                     req_source_valid;
   logic signed [SID_W-1:0]  req_source_id;
   logic [PL_W-1:0]          req_payload;
   logic [WANT_W-1:0]        req_max_wanted;
   logic                     rsp_valid;
   logic                     rsp_ok;
   logic signed [ID_W-1:0]   rsp_out_id;
   logic                     rsp_out_source_valid;
   logic signed [SID_W-1:0]  rsp_out_source_id;
   logic [PL_W-1:0]          rsp_out_payload;
   logic [FILL_W-1:0]        rsp_fill;
   logic [TOTAL_W-1:0]       rsp_total_added;
   logic                     rsp_last;

   ring_history_scoreboard sb;
   logic                   gaps_on;
   logic [ID_W-1:0]        known_ids[$];

   keyed_ring_history_store #(.DEPTH(RING_DEPTH)) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_record_id        (req_record_id),
      .req_source_valid     (req_source_valid),
      .req_source_id        (req_source_id),
      .req_payload          (req_payload),
      .req_max_wanted       (req_max_wanted),
      .rsp_valid            (rsp_valid),
      .rsp_ok               (rsp_ok),
      .rsp_out_id           (rsp_out_id),
      .rsp_out_source_valid (rsp_out_source_valid),
      .rsp_out_source_id    (rsp_out_source_id),
      .rsp_out_payload      (rsp_out_payload),
      .rsp_fill             (rsp_fill),
      .rsp_total_added      (rsp_total_added),
      .rsp_last             (rsp_last)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin : watch_replies
      reply_type r;
      if (!reset && rsp_valid) begin
         r.ok        = rsp_ok;
         r.id        = rsp_out_id;
         r.src_valid = rsp_out_source_valid;
         r.src_id    = rsp_out_source_id;
         r.payload   = rsp_out_payload;
         r.fill      = rsp_fill;
         r.total     = rsp_total_added;
         r.last      = rsp_last;
         sb.check_result(r);
      end
   end

   task automatic issue(cmd_type cmd, logic [ID_W-1:0] id, logic sv,
                        logic [SID_W-1:0] sid, logic [PL_W-1:0] pl,
                        logic [WANT_W-1:0] want);
      logic accepted;
      req_command      <= cmd;
      req_record_id    <= id;
      req_source_valid <= sv;
      req_source_id    <= sid;
      req_payload      <= pl;
      req_max_wanted   <= want;
      accepted = 1'b0;
      // while gaps are on, start may drop at any point, also while the block is busy
      while (!accepted) begin
         start <= !(gaps_on && $urandom_range(0, 99) < 11);
         @(posedge clock);
         accepted = start && !busy;
      end
      sb.note_request(cmd, id, sv, sid, pl, want);
   endtask

   function automatic logic [ID_W-1:0] fresh_id();
      logic [ID_W-1:0] v;
      v = $urandom & 32'h7fff_ffff;
      return (v == '0) ? 32'd1 : v;
   endfunction

   function automatic logic [ID_W-1:0] nonpositive_id();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         default: return $urandom | 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [ID_W-1:0] reused_id();
      if (known_ids.size() == 0) return fresh_id();
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
   endfunction

   function automatic logic [SID_W-1:0] pick_source();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return $urandom_range(1, 6);
      if (r < 30) return '0;
      if (r < 35) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'hffff_ffff;
      return $urandom;
   endfunction

   function automatic logic [WANT_W-1:0] pick_want();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 7'd64;
      if (r < 25) return 7'd1;
      if (r < 30) return 7'd0;
      return WANT_W'($urandom_range(0, 64));
   endfunction

   initial begin : stimulus
      cmd_type          cmd;
      logic [ID_W-1:0]  id;
      logic             sv;
      logic [SID_W-1:0] sid;
      logic [PL_W-1:0]  pl;
      logic [WANT_W-1:0] want;
      int               roll;
      int               pick;
      sb = new;
      gaps_on          = 1'b1;
      start            <= 1'b0;
      req_command      <= CMD_CLEAR;
      req_record_id    <= '0;
      req_source_valid <= 1'b0;
      req_source_id    <= '0;
      req_payload      <= '0;
      req_max_wanted   <= '0;
      reset            <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty ring, rejected ids, both kinds of in-place update, clamping
      issue(CMD_COPY,   32'd0,          1'b0, '0,           '0,             7'd64);
      issue(CMD_LOOKUP, 32'd1,          1'b0, '0,           '0,             7'd0);
      issue(CMD_APPEND, 32'd0,          1'b1, 32'd5,        '1,             7'd0);
      issue(CMD_APPEND, 32'h8000_0000,  1'b1, 32'd5,        '1,             7'd0);
      issue(CMD_APPEND, 32'hffff_ffff,  1'b0, '0,           '1,             7'd0);
      issue(CMD_APPEND, 32'd1,          1'b1, 32'd5,        '1,             7'd0);
      issue(CMD_APPEND, 32'h7fff_ffff,  1'b0, '0,           '0,             7'd0);
      issue(CMD_APPEND, 32'd2,          1'b1, 32'd5,        64'h0123_4567_89ab_cdef, 7'd0);
      issue(CMD_APPEND, 32'd3,          1'b1, '0,           64'h1,          7'd0);
      issue(CMD_APPEND, 32'd4,          1'b1, '0,           64'h2,          7'd0);
      issue(CMD_APPEND, 32'd9,          1'b0, 32'd5,        64'h3,          7'd0);
      issue(CMD_APPEND, 32'h7fff_ffff,  1'b1, 32'h8000_0000, {32{2'b01}},   7'd0);
      issue(CMD_LOOKUP, 32'h7fff_ffff,  1'b0, '0,           '0,             7'd0);
      issue(CMD_LOOKUP, 32'd1,          1'b0, '0,           '0,             7'd0);
      issue(CMD_LOOKUP, 32'd0,          1'b0, '0,           '0,             7'd0);
      issue(CMD_LOOKUP, 32'h8000_0000,  1'b0, '0,           '0,             7'd0);
      issue(CMD_COPY,   32'd0,          1'b0, '0,           '0,             7'd0);
      issue(CMD_COPY,   32'd0,          1'b0, '0,           '0,             7'd1);
      issue(CMD_COPY,   32'd0,          1'b0, '0,           '0,             7'd64);
      issue(CMD_CLEAR,  32'd0,          1'b0, '0,           '0,             7'd0);
      issue(CMD_COPY,   32'd0,          1'b0, '0,           '0,             7'd3);
      issue(CMD_APPEND, 32'd11,         1'b1, 32'hffff_ffff, {32{2'b10}},   7'd0);
      issue(CMD_LOOKUP, 32'd11,         1'b0, '0,           '0,             7'd0);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         gaps_on = !(k >= 180 && k < 290);
         roll = $urandom_range(0, 999);
         sv   = 1'($urandom_range(0, 1));
         sid  = pick_source();
         pl   = {$urandom, $urandom};
         want = pick_want();
         pick = $urandom_range(0, 99);
         if (roll < 8) begin
            cmd = CMD_CLEAR;
            id  = $urandom;
         end else if (roll < 620) begin
            // mostly new ids so the ring fills up and wraps
            cmd = CMD_APPEND;
            id  = (pick < 75) ? fresh_id() : (pick < 92) ? reused_id() : nonpositive_id();
         end else if (roll < 800) begin
            cmd = CMD_LOOKUP;
            id  = (pick < 65) ? reused_id() : (pick < 85) ? fresh_id() : nonpositive_id();
         end else begin
            cmd = CMD_COPY;
            id  = $urandom;
         end
         issue(cmd, id, sv, sid, pl, want);
         if (cmd == CMD_APPEND && id != '0 && !id[ID_W-1]) begin
            known_ids.push_back(id);
            if (known_ids.size() > 96) void'(known_ids.pop_front());
         end
      end
      start <= 1'b0;

      while (sb.awaited_replies.size() != 0) @(posedge clock);
      repeat (RING_DEPTH + 8) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
